### rtl/bdel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdel_pkg
// Shared sizes, request and status codes, and word types for the bounded
// double-ended list.
// ----------------------------------------------------------------------------
package bdel_pkg;

   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   localparam logic [CNT_BITS:0]   DEPTH_EXT = (CNT_BITS + 1)'(DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);
   localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(DEPTH - 1);

   // request codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_FIND       = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;
   localparam logic [2:0] OP_DROP_BACK  = 3'd6;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_MISS  = 2'd3;

   typedef struct packed {
      logic [2:0]                   req_type;
      logic signed [VALUE_BITS-1:0] item_value;
      logic [CNT_BITS-1:0]          drop_count;
   } request_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [VALUE_BITS-1:0] out_value;
      logic                         value_valid;
      logic [IDX_BITS-1:0]          found_position;
      logic [CNT_BITS-1:0]          entry_total;
      logic                         list_empty;
   } response_type;

   // slot index of a position counted from the front, offset below DEPTH
   function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] offset);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(offset);
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/bounded_double_ended_list.sv
`default_nettype none
// accept to rsp_valid: push, clear, no-op, drop on empty and refused requests go
//   straight to the done state; pops and drops that read the new end entry pass the
//   read state; find walks the scan state to a hit or the last entry (none if empty)
// done waits for a free output register; a new request is taken only once the previous
//   result enters that register, so requests never overlap; find scans one slot per cycle
// synchronous reset empties the list; slot contents are kept undefined
// ----------------------------------------------------------------------------
// bounded_double_ended_list
// Ring of value slots in a one-port-read, one-port-write memory, with a front
// index and an entry count; push/pop at both ends, find, clear, drop from back.
// ----------------------------------------------------------------------------
module bounded_double_ended_list (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  bdel_pkg::request_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output bdel_pkg::response_type rsp_data
);
   import bdel_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   front_ff, front_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [IDX_BITS-1:0]   chk_pos_ff, chk_pos_in;
   response_type          res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   response_type          rsp_data_ff, rsp_data_in;

   logic [VALUE_BITS-1:0] slot_mem [DEPTH];
   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   logic [VALUE_BITS-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_rd_data_ff;

   logic                  req_fire;
   logic                  rsp_free;
   logic [CNT_BITS-1:0]   cnt_dec;
   logic [CNT_BITS-1:0]   drop_left;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt_dec   = count_ff - CNT_ONE;
   assign drop_left = (req_data.drop_count >= count_ff) ? '0
                                                         : count_ff - req_data.drop_count;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      chk_pos_in   = chk_pos_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = front_ff;
      mem_wr_data  = req_data.item_value;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_data.req_type)
                  OP_PUSH_FRONT: begin
                     if (count_ff == CNT_FULL) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        front_in           = (front_ff == '0) ? IDX_LAST
                                                               : front_ff - IDX_BITS'(1);
                        mem_wr_en          = 1'b1;
                        mem_wr_addr        = front_in;
                        count_in           = count_ff + CNT_ONE;
                        res_in.out_value   = req_data.item_value;
                        res_in.value_valid = 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (count_ff == CNT_FULL) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_wr_en          = 1'b1;
                        mem_wr_addr        = ring_add(front_ff, count_ff);
                        count_in           = count_ff + CNT_ONE;
                        res_in.out_value   = req_data.item_value;
                        res_in.value_valid = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        front_in    = ring_add(front_ff, CNT_ONE);
                        count_in    = cnt_dec;
                        mem_rd_addr = front_in;
                        if (cnt_dec != '0) begin
                           mem_rd_en = 1'b1;
                           state_in  = S_READ;
                        end
                     end
                  end
                  OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        count_in    = cnt_dec;
                        mem_rd_addr = ring_add(front_ff, cnt_dec - CNT_ONE);
                        if (cnt_dec != '0) begin
                           mem_rd_en = 1'b1;
                           state_in  = S_READ;
                        end
                     end
                  end
                  OP_FIND: begin
                     key_in        = req_data.item_value;
                     res_in.status = STAT_MISS;
                     if (count_ff != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        chk_pos_in  = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     front_in = '0;
                  end
                  OP_DROP_BACK: begin
                     if (count_ff != '0) begin
                        count_in    = drop_left;
                        mem_rd_addr = ring_add(front_ff, drop_left - CNT_ONE);
                        if (drop_left != '0) begin
                           mem_rd_en = 1'b1;
                           state_in  = S_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.out_value   = mem_rd_data_ff;
            res_in.value_valid = 1'b1;
            state_in           = S_DONE;
         end
         S_SCAN: begin
            if (mem_rd_data_ff == key_ff) begin
               res_in.status         = STAT_OK;
               res_in.out_value      = key_ff;
               res_in.value_valid    = 1'b1;
               res_in.found_position = chk_pos_ff;
               state_in              = S_DONE;
            end else if (CNT_BITS'(chk_pos_ff) == cnt_dec) begin
               state_in = S_DONE;
            end else begin
               // read the next slot while this one is compared
               mem_rd_en   = 1'b1;
               mem_rd_addr = ring_add(front_ff, CNT_BITS'(chk_pos_ff) + CNT_ONE);
               chk_pos_in  = chk_pos_ff + IDX_BITS'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.entry_total = count_ff;
               rsp_data_in.list_empty  = (count_ff == '0);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      chk_pos_ff  <= chk_pos_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= slot_mem[mem_rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/bdel_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdel_checker
// Port-level checks on the result channel of the bounded double-ended list.
// ----------------------------------------------------------------------------
module bdel_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input bdel_pkg::response_type rsp_data
);
   import bdel_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled result word changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.list_empty == (rsp_data.entry_total == '0))
                    && (rsp_data.entry_total <= CNT_FULL))
      else $error("entry total and empty flag disagree");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value_valid |-> rsp_data.status == STAT_OK
                                             && !rsp_data.list_empty)
      else $error("value reported with a failing status or empty list");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         !rsp_data.value_valid && rsp_data.out_value == '0
         && rsp_data.found_position == '0)
      else $error("failed request left value or position set");

endmodule

bind bounded_double_ended_list bdel_checker u_bdel_checker (.*);

`default_nettype wire
